### hdl/wsd_pkg.sv
// Shared types, codes and result builders for the WebSocket frame deframer.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_SKIP    = 3'd6
   } phase_type;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
   localparam logic [2:0] ERR_SHORT_EXTLEN = 3'd2;
   localparam logic [2:0] ERR_SHORT_KEY    = 3'd3;
   localparam logic [2:0] ERR_SHORT_PAY    = 3'd4;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   typedef struct packed {
      logic [1:0]  kind;
      logic        fin_bit;
      logic [2:0]  reserved_bits;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] frame_length;
      logic [31:0] mask_key;
      logic [7:0]  payload_byte;
      logic        last_payload;
      logic [2:0]  error_code;
   } result_type;

   // flags: bits 8..1 hold byte one, bit 0 the mask bit
   function automatic result_type make_header(input logic [8:0] flags,
                                              input logic [63:0] len,
                                              input logic [31:0] key);
      result_type r;
      r               = '0;
      r.kind          = KIND_HEADER;
      r.fin_bit       = flags[8];
      r.reserved_bits = flags[7:5];
      r.opcode        = flags[4:1];
      r.masked        = flags[0];
      r.frame_length  = len;
      r.mask_key      = key;
      return r;
   endfunction

   function automatic result_type make_payload(input logic [7:0] data, input logic last);
      result_type r;
      r              = '0;
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = data;
      r.last_payload = last;
      return r;
   endfunction

   function automatic result_type make_error(input logic [2:0] code);
      result_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

endpackage

### hdl/wsd_chan_if.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface wsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        fin_bit;
   logic [2:0]  reserved_bits;
   logic [3:0]  opcode;
   logic        masked;
   logic [63:0] frame_length;
   logic [31:0] mask_key;
   logic [7:0]  payload_byte;
   logic        last_payload;
   logic [2:0]  error_code;

   modport source (output valid, output kind, output fin_bit, output reserved_bits,
                   output opcode, output masked, output frame_length,
                   output mask_key, output payload_byte, output last_payload,
                   output error_code, input ready);
   modport sink (input valid, input kind, input fin_bit, input reserved_bits,
                 input opcode, input masked, input frame_length,
                 input mask_key, input payload_byte, input last_payload,
                 input error_code, output ready);
endinterface

### hdl/websocket_frame_deframer.sv
// WebSocket frame deframer: parses one frame per received buffer, streams unmasked payload.
// The input stage registers each accepted byte, which is parsed from there; when the result
//   queue has room its results are written into the queue, whose head drives rsp.
// Throughput: one byte per cycle while the result queue holds no more than two entries;
//   the parse stage feeds a four-entry result queue that takes up to two results per byte.
// Reset (synchronous, active high) empties the input stage and queue, returns to frame start.
module websocket_frame_deframer (
   input logic        clock,
   input logic        reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);

   localparam int QDEPTH = 4;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       proc;

   // parser state
   wsd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  fbc_ff, fbc_in;
   logic [8:0]  hflags_ff, hflags_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] rem_ff, rem_in;
   logic [1:0]  kp_ff, kp_in;

   // result queue
   wsd_pkg::result_type res_q_ff [QDEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   wsd_pkg::result_type res0, res1, head;
   logic [1:0] n_res;
   logic       fin_hdr;

   logic [6:0] len7;
   logic       is_ext;
   logic [2:0] fbc_inc;
   logic       ext_done;
   logic       key_done;
   logic       last_pay;
   logic [7:0] key_byte;

   assign proc             = in_valid_ff && (count_ff <= 3'(QDEPTH - 2));
   assign req_chan.ready   = !in_valid_ff || proc;
   assign in_valid_in      = (req_chan.valid && req_chan.ready) || (in_valid_ff && !proc);

   assign len7     = in_byte_ff[6:0];
   assign is_ext   = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
   assign fbc_inc  = fbc_ff + 3'd1;
   // eight length bytes wrap the count back to zero
   assign ext_done = ((phase_ff == wsd_pkg::PH_EXT16) && (fbc_inc == 3'd2)) ||
                     ((phase_ff == wsd_pkg::PH_EXT64) && (fbc_inc == 3'd0));
   assign key_done = (fbc_inc == 3'd4);
   assign last_pay = (rem_ff == 64'd1);
   assign key_byte = key_ff[{~kp_ff, 3'b000} +: 8];

   // datapath next values and results
   always_comb begin
      hflags_in = hflags_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      fbc_in    = fbc_ff;
      rem_in    = rem_ff;
      kp_in     = kp_ff;
      res0      = '0;
      res1      = '0;
      n_res     = 2'd0;
      fin_hdr   = 1'b0;
      case (phase_ff)
         wsd_pkg::PH_FIRST: begin
            hflags_in = {in_byte_ff, 1'b0};
            len_in    = '0;
            key_in    = '0;
            fbc_in    = '0;
            if (in_end_ff) begin
               res0  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_HEADER);
               n_res = 2'd1;
            end
         end
         wsd_pkg::PH_SECOND: begin
            hflags_in = {hflags_ff[8:1], in_byte_ff[7]};
            fbc_in    = '0;
            if (is_ext) begin
               len_in = '0;
               if (in_end_ff) begin
                  res0  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_EXTLEN);
                  n_res = 2'd1;
               end
            end else begin
               len_in = {57'd0, len7};
               if (in_byte_ff[7]) begin
                  if (in_end_ff) begin
                     res0  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_KEY);
                     n_res = 2'd1;
                  end
               end else begin
                  fin_hdr = 1'b1;
               end
            end
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            len_in = {len_ff[55:0], in_byte_ff};
            fbc_in = fbc_inc;
            if (ext_done) begin
               fbc_in = '0;
               if (hflags_ff[0]) begin
                  if (in_end_ff) begin
                     res0  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_KEY);
                     n_res = 2'd1;
                  end
               end else begin
                  fin_hdr = 1'b1;
               end
            end else if (in_end_ff) begin
               res0  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_EXTLEN);
               n_res = 2'd1;
            end
         end
         wsd_pkg::PH_KEY: begin
            key_in = {key_ff[23:0], in_byte_ff};
            fbc_in = fbc_inc;
            if (key_done) begin
               fbc_in  = '0;
               fin_hdr = 1'b1;
            end else if (in_end_ff) begin
               res0  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_KEY);
               n_res = 2'd1;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            res0   = wsd_pkg::make_payload(in_byte_ff ^ key_byte, last_pay);
            n_res  = 2'd1;
            kp_in  = kp_ff + 2'd1;
            rem_in = rem_ff - 64'd1;
            if (!last_pay && in_end_ff) begin
               res1  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_PAY);
               n_res = 2'd2;
            end
         end
         default: begin
         end
      endcase
      if (fin_hdr) begin
         res0   = wsd_pkg::make_header(hflags_in, len_in, key_in);
         rem_in = len_in;
         kp_in  = '0;
         n_res  = 2'd1;
         if ((len_in != 64'd0) && in_end_ff) begin
            res1  = wsd_pkg::make_error(wsd_pkg::ERR_SHORT_PAY);
            n_res = 2'd2;
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         wsd_pkg::PH_FIRST: begin
            phase_in = in_end_ff ? wsd_pkg::PH_FIRST : wsd_pkg::PH_SECOND;
         end
         wsd_pkg::PH_SECOND: begin
            if (is_ext) begin
               if (in_end_ff) begin
                  phase_in = wsd_pkg::PH_FIRST;
               end else begin
                  phase_in = (len7 == wsd_pkg::LEN7_EXT16) ? wsd_pkg::PH_EXT16
                                                           : wsd_pkg::PH_EXT64;
               end
            end else if (in_byte_ff[7]) begin
               phase_in = in_end_ff ? wsd_pkg::PH_FIRST : wsd_pkg::PH_KEY;
            end
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            if (ext_done) begin
               if (hflags_ff[0]) begin
                  phase_in = in_end_ff ? wsd_pkg::PH_FIRST : wsd_pkg::PH_KEY;
               end
            end else if (in_end_ff) begin
               phase_in = wsd_pkg::PH_FIRST;
            end
         end
         wsd_pkg::PH_KEY: begin
            if (!key_done && in_end_ff) begin
               phase_in = wsd_pkg::PH_FIRST;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            if (in_end_ff) begin
               phase_in = wsd_pkg::PH_FIRST;
            end else if (last_pay) begin
               phase_in = wsd_pkg::PH_SKIP;
            end
         end
         default: begin
            if (in_end_ff) begin
               phase_in = wsd_pkg::PH_FIRST;
            end
         end
      endcase
      if (fin_hdr) begin
         if (in_end_ff) begin
            phase_in = wsd_pkg::PH_FIRST;
         end else if (len_in == 64'd0) begin
            phase_in = wsd_pkg::PH_SKIP;
         end else begin
            phase_in = wsd_pkg::PH_PAYLOAD;
         end
      end
   end

   // result queue control
   assign pop       = (count_ff != 3'd0) && rsp_chan.ready;
   assign count_in  = count_ff + (proc ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
   assign wr_ptr_in = proc ? 2'(wr_ptr_ff + n_res) : wr_ptr_ff;
   assign rd_ptr_in = pop ? 2'(rd_ptr_ff + 2'd1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= wsd_pkg::PH_FIRST;
         fbc_ff      <= '0;
         hflags_ff   <= '0;
         len_ff      <= '0;
         key_ff      <= '0;
         rem_ff      <= '0;
         kp_ff       <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (proc) begin
            phase_ff  <= phase_in;
            fbc_ff    <= fbc_in;
            hflags_ff <= hflags_in;
            len_ff    <= len_in;
            key_ff    <= key_in;
            rem_ff    <= rem_in;
            kp_ff     <= kp_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.buffer_end;
      end
      if (proc && (n_res != 2'd0)) begin
         res_q_ff[wr_ptr_ff] <= res0;
      end
      if (proc && (n_res == 2'd2)) begin
         res_q_ff[2'(wr_ptr_ff + 2'd1)] <= res1;
      end
   end

   assign head                   = res_q_ff[rd_ptr_ff];
   assign rsp_chan.valid         = (count_ff != 3'd0);
   assign rsp_chan.kind          = head.kind;
   assign rsp_chan.fin_bit       = head.fin_bit;
   assign rsp_chan.reserved_bits = head.reserved_bits;
   assign rsp_chan.opcode        = head.opcode;
   assign rsp_chan.masked        = head.masked;
   assign rsp_chan.frame_length  = head.frame_length;
   assign rsp_chan.mask_key      = head.mask_key;
   assign rsp_chan.payload_byte  = head.payload_byte;
   assign rsp_chan.last_payload  = head.last_payload;
   assign rsp_chan.error_code    = head.error_code;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue overflow");

   a_second_is_error: assert property (@(posedge clock) disable iff (reset)
      (proc && (n_res == 2'd2)) |-> (res1.kind == wsd_pkg::KIND_ERROR))
      else $error("second result of a byte is not an error");

   a_first_step: assert property (@(posedge clock) disable iff (reset)
      (proc && (phase_ff == wsd_pkg::PH_FIRST)) |=>
         ((phase_ff == wsd_pkg::PH_FIRST) || (phase_ff == wsd_pkg::PH_SECOND)))
      else $error("bad phase after first header byte");
`endif

endmodule
